>>> src/first_fit_block_allocator_core_macros.svh
// Assertion macros shared by the checker files.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define FFA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ffa_pkg.sv
package ffa_pkg;

    // Fixed field widths
    localparam int ADDR_BITS    = 20;
    localparam int SIZE_W       = 21;
    localparam int NEED_W       = SIZE_W + 2;
    localparam int HEADER_BYTES = 16;

    localparam logic [SIZE_W-1:0] HEAP_SPAN = SIZE_W'(1) << ADDR_BITS;
    localparam logic [SIZE_W-1:0] HDR       = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] LIMIT_RST = HEAP_SPAN;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_ZERO    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    // One heap table entry
    typedef struct packed
    {
        logic [ADDR_BITS-1:0] base;
        logic [SIZE_W-1:0]    size;
        logic                 free;
    } entry_t;

    // Controller to datapath
    typedef struct packed
    {
        logic start;
        logic scan;
        logic commit_hit;
        logic commit_miss;
        logic deliver;
    } ffa_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic hit;
        logic miss;
        logic out_free;
    } ffa_stat_t;

endpackage

>>> src/ffa_ifs.sv
// Request channel
interface ffa_req_if;
    import ffa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [SIZE_W-1:0]    req_size;
    logic [ADDR_BITS-1:0] block_addr;

    modport source (output valid, operation, req_size, block_addr, input ready);
    modport sink   (input valid, operation, req_size, block_addr, output ready);
endinterface

// Response channel
interface ffa_rsp_if;
    import ffa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] user_addr;
    logic                 reused;

    modport source (output valid, status, user_addr, reused, input ready);
    modport sink   (input valid, status, user_addr, reused, output ready);
endinterface

// Configuration write channel
interface ffa_cfg_if;
    import ffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] heap_limit;

    modport source (output valid, heap_limit, input ready);
    modport sink   (input valid, heap_limit, output ready);
endinterface

>>> src/ffa_ctrl.sv
module ffa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffa_pkg::ffa_stat_t stat,
    output ffa_pkg::ffa_cmd_t  cmd
);
    import ffa_pkg::*;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_DELIVER
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit || stat.miss)
                begin
                    state_next = S_DELIVER;
                end
            end
            S_DELIVER:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands
    always_comb
    begin
        in_ready        = (state_reg == S_IDLE);
        cmd.start       = (state_reg == S_IDLE) && in_valid;
        cmd.scan        = (state_reg == S_SCAN);
        cmd.commit_hit  = (state_reg == S_SCAN) && stat.hit;
        cmd.commit_miss = (state_reg == S_SCAN) && !stat.hit && stat.miss;
        cmd.deliver     = (state_reg == S_DELIVER) && stat.out_free;
    end

endmodule

>>> src/ffa_dpath.sv
module ffa_dpath #(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // request payload
    input  logic                           operation,
    input  logic [ffa_pkg::SIZE_W-1:0]     req_size,
    input  logic [ffa_pkg::ADDR_BITS-1:0]  block_addr,
    // configuration
    input  logic                           cfg_we,
    input  logic [ffa_pkg::SIZE_W-1:0]     cfg_data,
    // response
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     out_status,
    output logic [ffa_pkg::ADDR_BITS-1:0]  out_user_addr,
    output logic                           out_reused,
    // control
    input  ffa_pkg::ffa_cmd_t              cmd,
    output ffa_pkg::ffa_stat_t             stat
);
    import ffa_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    // Heap table
    entry_t mem [MAX_BLOCKS];

    logic [SIZE_W-1:0]    limit_reg;
    logic [CW-1:0]        count_reg,   count_next;
    logic [SIZE_W-1:0]    break_reg,   break_next;
    logic                 op_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [CW-1:0]        rd_idx_reg,  rd_idx_next;
    logic [IW-1:0]        chk_idx_reg;
    logic                 chk_valid_reg, chk_valid_next;
    entry_t               rd_data_reg;
    status_t              res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_addr_reg,   res_addr_next;
    logic                 res_reused_reg, res_reused_next;
    logic                 out_valid_reg;

    logic                 mem_we;
    logic [IW-1:0]        mem_wa;
    entry_t               mem_wd;
    logic                 issue;
    logic                 trivial;
    logic                 match;
    logic                 is_last;
    logic                 nospace;
    logic [SIZE_W-1:0]    limit_eff;
    logic [SIZE_W-1:0]    hit_uaddr;
    logic [SIZE_W-1:0]    brk_uaddr;
    logic [NEED_W-1:0]    need;

    // Heap limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= operation;
            size_reg <= req_size;
            addr_reg <= block_addr;
        end
    end

    // Scan pointer: one read issued per cycle, compared in the cycle after
    always_comb
    begin
        issue          = cmd.scan && (rd_idx_reg < count_reg);
        rd_idx_next    = rd_idx_reg;
        chk_valid_next = 1'b0;
        if (cmd.start)
        begin
            rd_idx_next = '0;
        end
        else if (issue)
        begin
            rd_idx_next    = rd_idx_reg + CW'(1);
            chk_valid_next = 1'b1;
        end
    end

    // Entry compare
    always_comb
    begin
        trivial   = (op_reg == OP_ALLOC) ? (size_reg == '0) : (addr_reg == '0);
        hit_uaddr = {1'b0, rd_data_reg.base} + HDR;
        if (op_reg == OP_ALLOC)
        begin
            match = rd_data_reg.free && (rd_data_reg.size >= size_reg);
        end
        else
        begin
            match = (hit_uaddr == {1'b0, addr_reg});
        end
        is_last   = ((CW'(chk_idx_reg) + CW'(1)) == count_reg);
        stat.hit  = chk_valid_reg && match && !trivial;
        stat.miss = trivial || (!chk_valid_reg && (rd_idx_reg >= count_reg));
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Append check against the break
    always_comb
    begin
        limit_eff = (limit_reg > HEAP_SPAN) ? HEAP_SPAN : limit_reg;
        need      = NEED_W'(break_reg) + NEED_W'(HDR) + NEED_W'(size_reg);
        brk_uaddr = break_reg + HDR;
        nospace   = (count_reg >= CW'(MAX_BLOCKS)) || (need > NEED_W'(limit_eff));
    end

    // Table and break update at commit
    always_comb
    begin
        count_next      = count_reg;
        break_next      = break_reg;
        mem_we          = 1'b0;
        mem_wa          = chk_idx_reg;
        mem_wd          = rd_data_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_reused_next = res_reused_reg;
        if (cmd.commit_hit)
        begin
            res_status_next = ST_DONE;
            res_addr_next   = '0;
            res_reused_next = 1'b0;
            if (op_reg == OP_ALLOC)
            begin
                mem_we          = 1'b1;
                mem_wd.free     = 1'b0;
                res_addr_next   = hit_uaddr[ADDR_BITS-1:0];
                res_reused_next = 1'b1;
            end
            else if (is_last)
            begin
                // trim the tail block
                count_next = count_reg - CW'(1);
                break_next = {1'b0, rd_data_reg.base};
            end
            else
            begin
                mem_we      = 1'b1;
                mem_wd.free = 1'b1;
            end
        end
        else if (cmd.commit_miss)
        begin
            res_addr_next   = '0;
            res_reused_next = 1'b0;
            if (trivial)
            begin
                res_status_next = (op_reg == OP_ALLOC) ? ST_ZERO : ST_DONE;
            end
            else if (op_reg == OP_FREE)
            begin
                res_status_next = ST_UNKNOWN;
            end
            else if (nospace)
            begin
                res_status_next = ST_NOSPACE;
            end
            else
            begin
                // append a new block at the break
                mem_we          = 1'b1;
                mem_wa          = count_reg[IW-1:0];
                mem_wd.base     = break_reg[ADDR_BITS-1:0];
                mem_wd.size     = size_reg;
                mem_wd.free     = 1'b0;
                count_next      = count_reg + CW'(1);
                break_next      = need[SIZE_W-1:0];
                res_status_next = ST_DONE;
                res_addr_next   = brk_uaddr[ADDR_BITS-1:0];
            end
        end
    end

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_idx_reg[IW-1:0]];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            break_reg     <= '0;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            break_reg     <= break_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
            if (cmd.deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result holding and output registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= rd_idx_reg[IW-1:0];
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_reused_reg <= res_reused_next;
        if (cmd.deliver)
        begin
            out_status    <= res_status_reg;
            out_user_addr <= res_addr_reg;
            out_reused    <= res_reused_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/first_fit_block_allocator_core.sv
// First-fit heap allocator with tail trim. Each request beat is an allocate or a
// free and yields exactly one response beat. Requests are handled one at a time,
// because the heap table sits in a memory with one read port that is scanned one
// entry per cycle with a registered read. A scan ends at the first entry that hits,
// or with a miss once all entries of the table are looked at. Zero-size allocates,
// null frees and any request on an empty table are settled without a table hit.
// A finished result waits while the previous response still sits in the output
// register. The response sits in that output register, so a new request is taken
// while an earlier response waits. No clearing pass is needed after reset. Write
// heap_limit only while the block is idle.
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp,
    ffa_cfg_if.sink   cfg
);
    import ffa_pkg::*;

    ffa_cmd_t  cmd;
    ffa_stat_t stat;

    assign cfg.ready = 1'b1;

    ffa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffa_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (req.operation),
        .req_size      (req.req_size),
        .block_addr    (req.block_addr),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.heap_limit),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_status    (rsp.status),
        .out_user_addr (rsp.user_addr),
        .out_reused    (rsp.reused),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> src/ffa_checker.sv
`include "first_fit_block_allocator_core_macros.svh"

module ffa_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [1:0]                    rsp_status,
    input logic [ffa_pkg::ADDR_BITS-1:0] rsp_user_addr,
    input logic                          rsp_reused
);
    import ffa_pkg::*;

    // one request in flight at a time
    `FFA_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

    // a response appears only after the block was busy
    `FFA_ASSERT_IMP(a_rsp_after_work, clk, rst_n, $rose(rsp_valid), $past(!req_ready), "response without work")

    // stalled response beat holds
    `FFA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_user_addr), "response dropped")

    // a reused grant is a successful allocate with a real address
    `FFA_ASSERT_IMP(a_reuse_ok, clk, rst_n, rsp_valid && rsp_reused, (rsp_status == ST_DONE) && (rsp_user_addr != '0), "bad reuse beat")

endmodule

bind first_fit_block_allocator_core ffa_checker u_ffa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_user_addr (rsp.user_addr),
    .rsp_reused    (rsp.reused)
);

>>> dv/first_fit_block_allocator_core_test.sv
module first_fit_block_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int TABLE_DEPTH     = 64;
    localparam int DIR_ROWS        = 23;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 191;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int CYCLE_LIMIT     = 1000000;

    // Expected response beat
    typedef struct packed
    {
        status_t              status;
        logic [ADDR_BITS-1:0] user_addr;
        logic                 reused;
    } alloc_reply_t;

    // One directed request, with a hand-written reply where it is obvious
    typedef struct
    {
        op_t                  op;
        logic [SIZE_W-1:0]    size;
        logic [ADDR_BITS-1:0] addr;
        bit                   known;
        alloc_reply_t         reply;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ffa_req_if req_bus ();
    ffa_rsp_if rsp_bus ();
    ffa_cfg_if cfg_bus ();

    first_fit_block_allocator_core #(.MAX_BLOCKS(TABLE_DEPTH)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Shadow heap table and break
    logic [ADDR_BITS-1:0] heap_base [TABLE_DEPTH];
    logic [SIZE_W-1:0]    heap_size [TABLE_DEPTH];
    logic                 heap_free [TABLE_DEPTH];
    int                   heap_count;
    logic [SIZE_W-1:0]    heap_brk;
    logic [SIZE_W-1:0]    heap_limit_reg;

    alloc_reply_t reply_q [$];
    int           failures;
    bit           idle_on;
    bit           hold_off_req;
    int           cycles;

    // Walk through reuse, double free, trim and the heap edges from an empty heap
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{OP_ALLOC, 21'd0,       20'hFFFFF, 1'b1, '{ST_ZERO,    20'd0,  1'b0}},
        '{OP_FREE,  21'd1048576, 20'd0,     1'b1, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'hFFFFF, 1'b1, '{ST_UNKNOWN, 20'd0,  1'b0}},
        '{OP_ALLOC, 21'd1,       20'd0,     1'b1, '{ST_DONE,    20'd16, 1'b0}},
        '{OP_ALLOC, 21'd100,     20'd0,     1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_ALLOC, 21'd8,       20'd0,     1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd33,    1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd33,    1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_ALLOC, 21'd50,      20'd0,     1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd33,    1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd149,   1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_ALLOC, 21'd200,     20'd0,     1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd149,   1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd33,    1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd17,    1'b1, '{ST_UNKNOWN, 20'd0,  1'b0}},
        '{OP_ALLOC, 21'd1048576, 20'd0,     1'b1, '{ST_NOSPACE, 20'd0,  1'b0}},
        '{OP_ALLOC, 21'd1048543, 20'd0,     1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_ALLOC, 21'd1,       20'd0,     1'b1, '{ST_NOSPACE, 20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd33,    1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_FREE,  21'd0,       20'd16,    1'b0, '{ST_DONE,    20'd0,  1'b0}},
        '{OP_ALLOC, 21'd1048576, 20'd0,     1'b1, '{ST_NOSPACE, 20'd0,  1'b0}},
        '{OP_ALLOC, 21'd1048560, 20'd0,     1'b1, '{ST_DONE,    20'd16, 1'b0}},
        '{OP_FREE,  21'd0,       20'd16,    1'b1, '{ST_DONE,    20'd0,  1'b0}}
    };

    // Apply one request to the shadow heap and return its reply
    function automatic alloc_reply_t serve_request(input op_t op,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [ADDR_BITS-1:0] addr);
        alloc_reply_t      r;
        logic [NEED_W-1:0] need;
        logic [NEED_W-1:0] cap;
        int                slot;
        r.status    = ST_DONE;
        r.user_addr = '0;
        r.reused    = 1'b0;
        slot        = -1;
        if (op == OP_ALLOC) begin
            if (size == '0) begin
                r.status = ST_ZERO;
                return r;
            end
            // first free entry that is large enough, no split
            for (int i = 0; i < heap_count; i++)
                if (slot < 0 && heap_free[i] && heap_size[i] >= size)
                    slot = i;
            if (slot >= 0) begin
                heap_free[slot] = 1'b0;
                r.user_addr     = heap_base[slot] + ADDR_BITS'(HEADER_BYTES);
                r.reused        = 1'b1;
                return r;
            end
            // append at the break
            cap  = (heap_limit_reg > HEAP_SPAN) ? NEED_W'(HEAP_SPAN) : NEED_W'(heap_limit_reg);
            need = NEED_W'(heap_brk) + NEED_W'(HDR) + NEED_W'(size);
            if (heap_count >= TABLE_DEPTH || need > cap) begin
                r.status = ST_NOSPACE;
                return r;
            end
            heap_base[heap_count] = ADDR_BITS'(heap_brk);
            heap_size[heap_count] = size;
            heap_free[heap_count] = 1'b0;
            heap_count++;
            r.user_addr = ADDR_BITS'(heap_brk + HDR);
            heap_brk    = SIZE_W'(need);
            return r;
        end
        // free
        if (addr == '0)
            return r;
        for (int i = 0; i < heap_count; i++)
            if (slot < 0 && SIZE_W'(heap_base[i]) + HDR == SIZE_W'(addr))
                slot = i;
        if (slot < 0)
            r.status = ST_UNKNOWN;
        else if (slot == heap_count - 1) begin
            // tail trim, even if already free
            heap_brk = SIZE_W'(heap_base[slot]);
            heap_count--;
        end
        else
            heap_free[slot] = 1'b1;
        return r;
    endfunction

    // Random request shaped by the current shadow heap
    task automatic pick_request(input int alloc_pct, input int big_pct, output op_t op,
                                output logic [SIZE_W-1:0] size,
                                output logic [ADDR_BITS-1:0] addr);
        int roll;
        int slot;
        size = SIZE_W'($urandom_range(0, 1048576));
        addr = ADDR_BITS'($urandom);
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < alloc_pct) begin
            op = OP_ALLOC;
            if (roll < 3)
                size = '0;
            else if (roll < 3 + big_pct)
                ; // keep the full-range size
            else if (roll < 25)
                size = SIZE_W'($urandom_range(1, 4096));
            else
                size = SIZE_W'($urandom_range(1, 256));
        end
        else begin
            op = OP_FREE;
            if (roll < 5)
                addr = '0;
            else if (roll >= 15 && heap_count > 0) begin
                // mostly a live block, often the last one
                slot = (roll < 40) ? heap_count - 1 : $urandom_range(0, heap_count - 1);
                addr = heap_base[slot] + ADDR_BITS'(HEADER_BYTES);
            end
        end
    endtask

    // Drive one request beat, predict at acceptance, then maybe idle
    task automatic send_request(input op_t op, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_BITS-1:0] addr, input bit known,
                                input alloc_reply_t typed_reply);
        alloc_reply_t predicted;
        @(negedge clk);
        req_bus.valid      <= 1'b1;
        req_bus.operation  <= op;
        req_bus.req_size   <= size;
        req_bus.block_addr <= addr;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = serve_request(op, size, addr);
        reply_q.push_back(known ? typed_reply : predicted);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10) - 1)
                @(negedge clk);
        end
    endtask

    // Lower valid and wait for every outstanding reply
    task automatic drain_replies();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_limit(input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.heap_limit <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        heap_limit_reg = value;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Response ready: random stalls, plus one long hold-off on request
    initial
    begin : rsp_ready_gen
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
                rsp_bus.ready <= 1'b1;
                hold_off_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 10);
                rsp_bus.ready <= 1'b0;
                repeat (burst)
                    @(negedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Compare each response beat with the oldest expected reply
    always @(posedge clk)
    begin : reply_check
        alloc_reply_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (reply_q.size() == 0) begin
                $error("response beat with nothing outstanding: status %0d user_addr 0x%05h",
                       rsp_bus.status, rsp_bus.user_addr);
                failures++;
            end
            else begin
                want = reply_q.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    failures++;
                end
                if (rsp_bus.user_addr !== want.user_addr) begin
                    $error("user_addr: expected 0x%05h, got 0x%05h",
                           want.user_addr, rsp_bus.user_addr);
                    failures++;
                end
                if (rsp_bus.reused !== want.reused) begin
                    $error("reused: expected %0b, got %0b", want.reused, rsp_bus.reused);
                    failures++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin : stimulus
        op_t                  op;
        logic [SIZE_W-1:0]    size;
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_W-1:0]    limit;
        int                   alloc_pct;
        int                   big_pct;
        alloc_reply_t         no_reply;

        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.operation  = OP_ALLOC;
        req_bus.req_size   = '0;
        req_bus.block_addr = '0;
        rsp_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.heap_limit = '0;
        failures           = 0;
        idle_on            = 1'b1;
        hold_off_req       = 1'b0;
        heap_count         = 0;
        heap_brk           = '0;
        heap_limit_reg     = LIMIT_RST;
        no_reply           = '0;

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, heap limit at its reset value
        for (int i = 0; i < DIR_ROWS; i++)
            send_request(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
                         directed_rows[i].known, directed_rows[i].reply);
        drain_replies();

        // Random phases, each under its own heap limit
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin limit = 21'h1FFFFF;  alloc_pct = 85; big_pct = 0; end
                1: begin limit = 21'd4096;    alloc_pct = 50; big_pct = 5; end
                2: begin limit = 21'd0;       alloc_pct = 50; big_pct = 5; end
                3: begin limit = LIMIT_RST;   alloc_pct = 60; big_pct = 5; end
                4: begin
                    limit     = SIZE_W'($urandom_range(0, 21'h1FFFFF));
                    alloc_pct = 55;
                    big_pct   = 5;
                end
                5: begin limit = 21'd600;     alloc_pct = 50; big_pct = 3; end
                6: begin limit = 21'd1048575; alloc_pct = 70; big_pct = 3; end
                default: begin limit = LIMIT_RST; alloc_pct = 60; big_pct = 2; end
            endcase
            idle_on = (p < PHASES - 1);
            write_heap_limit(limit);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long response hold-off while requests keep coming
                if (p == 1 && n == 40)
                    hold_off_req = 1'b1;
                // sender pause until the block has answered everything
                if (p == 3 && n == 100)
                    drain_replies();
                pick_request(alloc_pct, big_pct, op, size, addr);
                send_request(op, size, addr, 1'b0, no_reply);
            end
            drain_replies();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
